// ===== hw/rtl/tpsw_pkg.sv =====
// Shared types and constants of the timer PWM square-wave synthesizer.
package tpsw_pkg;

  localparam int unsigned CLK_W    = 23;
  localparam int unsigned CEIL_W   = 17;
  localparam int unsigned SAMPLE_W = 15;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned PER_W    = 9;

  localparam logic [CNT_W-1:0]    MAX_RESULTS     = 6'd57;
  localparam logic [CLK_W-1:0]    DEFAULT_CLOCK   = 23'd600000;
  localparam logic [CEIL_W-1:0]   DEFAULT_CEILING = 17'd20000;
  localparam logic signed [SAMPLE_W-1:0] LEVEL_HIGH = 15'sd9000;
  localparam logic signed [SAMPLE_W-1:0] LEVEL_LOW  = -15'sd9000;
  localparam logic signed [SAMPLE_W-1:0] LEVEL_OFF  = 15'sd0;

  localparam logic CMD_RETUNE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic REG_CLOCK_FREQ   = 1'b0;
  localparam logic REG_AUDIBLE_CEIL = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/tpsw_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module tpsw_div #(
  parameter int unsigned NW    = 55,
  parameter int unsigned DV_W  = 25,
  parameter int unsigned STP_W = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [STP_W-1:0]      steps_i,
  input  logic [NW-1:0]         dividend_i,
  input  logic [DV_W-1:0]       divisor_i,
  output tpsw_pkg::div_status_t status_o,
  output logic [NW-1:0]         quotient_o,
  output logic [DV_W-1:0]       remainder_o
);
  import tpsw_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [STP_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    num_q, num_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DV_W-1:0]  den_q, den_d;
  logic [DV_W-1:0]  rem_q, rem_d;

  logic [DV_W:0] trial;
  logic [DV_W:0] diff;
  logic          fits;

  // The dividend enters MSB first; the partial remainder always stays below the divisor.
  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      num_d  = dividend_i;
      den_d  = divisor_i;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = num_q << 1;
      quo_d = {quo_q[NW-2:0], fits};
      rem_d = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
      cnt_d = cnt_q - STP_W'(1);
      if (cnt_q == STP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

// ===== hw/rtl/timer_pwm_square_wave_synth.sv =====
// Top level of the timer PWM square-wave synthesizer.
// A retune beat that yields a tone passes the check state and then runs the shared
// divider that forms the phase increment; a retune beat that goes silent returns to idle
// from the check state. A tick beat loads the divider and divides the elapsed-cycle
// total by the clock, then for each output sample adds the phase step, then multiplies
// and compares, for up to 57 samples, holding while the output is stalled.
// The input stalls throughout that work; the last sample of a tick may still wait in
// the output register when the next beat is taken. Zero in either configuration
// register selects its default value.
module timer_pwm_square_wave_synth #(
  parameter int unsigned SAMPLE_RATE = 44100,
  parameter int unsigned PHASE_BITS  = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [tpsw_pkg::CLK_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  cmd_i,
  input  logic                                  timer_run_i,
  input  logic [7:0]                            reload_value_i,
  input  logic [7:0]                            compare_value_i,
  input  logic [8:0]                            cycles_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tpsw_pkg::SAMPLE_W-1:0]  sample_o,
  output logic                                  last_o
);
  import tpsw_pkg::*;

  localparam int unsigned TOT_W = $clog2((2**CLK_W - 1) + 511 * SAMPLE_RATE + 1);
  localparam int unsigned DEN_W = $clog2(256 * SAMPLE_RATE + 1);
  localparam int unsigned DV_W  = (DEN_W > CLK_W) ? DEN_W : CLK_W;
  localparam int unsigned NW    = (CLK_W + PHASE_BITS > TOT_W) ? CLK_W + PHASE_BITS : TOT_W;
  localparam int unsigned STP_W = $clog2(NW + 1);
  localparam int unsigned PRD_W = PHASE_BITS + PER_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RT_CHK  = 6'b000010,
    ST_RT_DIV  = 6'b000100,
    ST_TK_LOAD = 6'b001000,
    ST_TK_DIV  = 6'b010000,
    ST_SMP_ADV = 6'b100000
  } state_e;

  // One more state would overflow six bits nicely; keep the sample output state separate.
  typedef enum logic [1:0] {
    PH_ADV = 2'b01,
    PH_OUT = 2'b10
  } phase_e;

  state_e state_q, state_d;
  phase_e smp_q, smp_d;

  logic [CLK_W-1:0]  clock_q, clock_d;
  logic [CEIL_W-1:0] ceil_q, ceil_d;

  logic                  tone_on_q, tone_on_d;
  logic [PHASE_BITS-1:0] step_q, step_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PER_W-1:0]      period_q, period_d;
  logic [7:0]            high_q, high_d;
  logic [CLK_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic       run_q;
  logic [7:0] reload_q, compare_q;
  logic [8:0] cyc_q;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       last_q, last_d;

  logic                  in_acc;
  logic                  out_free;
  logic [CLK_W-1:0]      eff_clk;
  logic [CEIL_W-1:0]     eff_ceil;
  logic [PER_W-1:0]      period_c;
  logic [7:0]            high_c;
  logic [CEIL_W+PER_W-1:0] ceil_lim;
  logic [DEN_W-1:0]      den_c;
  logic                  silent_c;
  logic [TOT_W-1:0]      total_c;
  logic [PRD_W-1:0]      prod_c;
  logic                  is_high;

  logic             div_start;
  logic [STP_W-1:0] div_steps;
  logic [NW-1:0]    div_num;
  logic [DV_W-1:0]  div_den;
  div_status_t      div_st;
  logic [NW-1:0]    div_quo;
  logic [DV_W-1:0]  div_rem;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign eff_clk  = (clock_q == '0) ? DEFAULT_CLOCK : clock_q;
  assign eff_ceil = (ceil_q == '0) ? DEFAULT_CEILING : ceil_q;

  // Retune arithmetic on the captured timer registers.
  assign period_c = 9'd256 - {1'b0, reload_q};
  assign high_c   = (compare_q >= reload_q) ? (compare_q - reload_q) : 8'd0;
  assign ceil_lim = (CEIL_W+PER_W)'(eff_ceil) * (CEIL_W+PER_W)'(period_c);
  assign den_c    = DEN_W'(period_c) * DEN_W'(SAMPLE_RATE);
  assign silent_c = !run_q || (period_c <= 9'd1) || (high_c == 8'd0) ||
                    ({1'b0, high_c} >= period_c) ||
                    ((CEIL_W+PER_W)'(eff_clk) > ceil_lim);

  assign total_c = TOT_W'(rem_q) + TOT_W'(cyc_q) * TOT_W'(SAMPLE_RATE);

  // The sample is high while phase * period < high * 2^PHASE_BITS.
  assign prod_c  = PRD_W'(phase_q) * PRD_W'(period_q);
  assign is_high = prod_c < (PRD_W'(high_q) << PHASE_BITS);

  always_comb begin
    div_start = 1'b0;
    div_steps = STP_W'(TOT_W);
    div_num   = NW'(total_c) << (NW - TOT_W);
    div_den   = DV_W'(eff_clk);
    if (state_q == ST_RT_CHK) begin
      div_start = !silent_c;
      div_steps = STP_W'(CLK_W + PHASE_BITS);
      div_num   = NW'(eff_clk) << (NW - CLK_W);
      div_den   = DV_W'(den_c);
    end else if (state_q == ST_TK_LOAD) begin
      div_start = 1'b1;
    end
  end

  tpsw_div #(
    .NW   (NW),
    .DV_W (DV_W),
    .STP_W(STP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .status_o   (div_st),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    clock_d = clock_q;
    ceil_d  = ceil_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLOCK_FREQ:   clock_d = cfg_data_i;
        REG_AUDIBLE_CEIL: ceil_d  = cfg_data_i[CEIL_W-1:0];
        default:          clock_d = clock_q;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    smp_d       = smp_q;
    tone_on_d   = tone_on_q;
    step_d      = step_q;
    phase_d     = phase_q;
    period_d    = period_q;
    high_d      = high_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    sample_d    = sample_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_TICK) begin
            state_d = ST_TK_LOAD;
          end else begin
            tone_on_d = 1'b0;
            state_d   = ST_RT_CHK;
          end
        end
      end
      ST_RT_CHK: begin
        period_d = period_c;
        high_d   = high_c;
        state_d  = silent_c ? ST_IDLE : ST_RT_DIV;
      end
      ST_RT_DIV: begin
        if (div_st.done) begin
          step_d    = div_quo[PHASE_BITS-1:0];
          tone_on_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_TK_LOAD: begin
        state_d = ST_TK_DIV;
      end
      ST_TK_DIV: begin
        if (div_st.done) begin
          rem_d = div_rem[CLK_W-1:0];
          // Whole samples beyond the cap are dropped; only the remainder carries over.
          if (div_quo > NW'(MAX_RESULTS)) begin
            cnt_d = MAX_RESULTS;
          end else begin
            cnt_d = div_quo[CNT_W-1:0];
          end
          if (div_quo == '0) begin
            state_d = ST_IDLE;
          end else begin
            smp_d   = PH_ADV;
            state_d = ST_SMP_ADV;
          end
        end
      end
      ST_SMP_ADV: begin
        unique case (smp_q)
          PH_ADV: begin
            if (tone_on_q) begin
              phase_d = phase_q + step_q;
            end
            smp_d = PH_OUT;
          end
          PH_OUT: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              sample_d    = !tone_on_q ? LEVEL_OFF : (is_high ? LEVEL_HIGH : LEVEL_LOW);
              last_d      = (cnt_q == CNT_W'(1));
              cnt_d       = cnt_q - CNT_W'(1);
              smp_d       = PH_ADV;
              if (cnt_q == CNT_W'(1)) begin
                state_d = ST_IDLE;
              end
            end
          end
          default: smp_d = PH_ADV;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      smp_q       <= PH_ADV;
      clock_q     <= DEFAULT_CLOCK;
      ceil_q      <= DEFAULT_CEILING;
      tone_on_q   <= 1'b0;
      step_q      <= '0;
      phase_q     <= '0;
      period_q    <= '0;
      high_q      <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      smp_q       <= smp_d;
      clock_q     <= clock_d;
      ceil_q      <= ceil_d;
      tone_on_q   <= tone_on_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      high_q      <= high_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_q     <= timer_run_i;
      reload_q  <= reload_value_i;
      compare_q <= compare_value_i;
      cyc_q     <= cycles_i;
    end
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q) && $onehot(smp_q))
    else $error("sequencer state is not one-hot");

  a_div_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RT_DIV || state_q == ST_TK_DIV) && !div_st.done |-> div_st.busy)
    else $error("waiting on the divider while it is idle");

  a_tone_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_on_q |-> (period_q > 9'd1) && (high_q != 8'd0) && ({1'b0, high_q} < period_q))
    else $error("tone enabled with an unusable period or duty");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SMP_ADV |-> cnt_q != '0)
    else $error("sample loop running with no samples left");

endmodule

// ===== dv/timer_pwm_square_wave_synth_test.sv =====
// Self-checking testbench for the timer PWM square-wave synthesizer.
module timer_pwm_square_wave_synth_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsw_pkg::*;

  localparam int unsigned SAMPLE_RATE = 44100;
  localparam int unsigned NUM_PHASES  = 9;

  typedef struct packed {
    logic       cmd;
    logic       run;
    logic [7:0] reload;
    logic [7:0] compare;
    logic [8:0] cycles;
  } timer_beat_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] level;
    logic                       last;
  } pcm_beat_t;

  class tone_scoreboard;
    logic [CLK_W-1:0]  clock_reg;
    logic [CEIL_W-1:0] ceiling_reg;
    bit                tone_active;
    logic [31:0]       phase_step;
    logic [PER_W-1:0]  period_len;
    logic [7:0]        high_len;
    logic [31:0]       phase;
    logic [CLK_W-1:0]  leftover;
    pcm_beat_t         expected_samples[$];
    int unsigned       mismatches;

    function new();
      clock_reg   = DEFAULT_CLOCK;
      ceiling_reg = DEFAULT_CEILING;
      tone_active = 0;
      phase_step  = '0;
      period_len  = '0;
      high_len    = '0;
      phase       = '0;
      leftover    = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic idx, logic [CLK_W-1:0] data);
      if (idx == REG_CLOCK_FREQ) clock_reg = data;
      else ceiling_reg = data[CEIL_W-1:0];
    endfunction

    function longint unsigned source_clock();
      return (clock_reg != 0) ? longint'(clock_reg) : longint'(DEFAULT_CLOCK);
    endfunction

    // Phase and the fractional remainder survive a retune; only the tone settings change.
    function void retune(logic run, logic [7:0] reload, logic [7:0] compare);
      longint unsigned period, high, clk, ceil, den;
      period = 256 - longint'(reload);
      clk = source_clock();
      ceil = (ceiling_reg != 0) ? longint'(ceiling_reg) : longint'(DEFAULT_CEILING);
      tone_active = 0;
      if (!run || period <= 1) return;
      high = (compare >= reload) ? longint'(compare) - longint'(reload) : 0;
      period_len = period[PER_W-1:0];
      high_len = high[7:0];
      if (high == 0 || high >= period) return;
      if (clk > ceil * period) return;
      den = period * SAMPLE_RATE;
      phase_step = 32'(((clk % den) << 32) / den);
      tone_active = 1;
    endfunction

    function void advance(logic [8:0] cycles);
      longint unsigned clk, total, whole;
      pcm_beat_t s;
      clk = source_clock();
      total = longint'(leftover) + longint'(cycles) * SAMPLE_RATE;
      whole = total / clk;
      leftover = CLK_W'(total % clk);
      if (whole > MAX_RESULTS) whole = MAX_RESULTS;
      for (int i = 0; i < int'(whole); i++) begin
        if (!tone_active) begin
          s.level = LEVEL_OFF;
        end else begin
          phase = phase + phase_step;
          if (longint'(phase) * longint'(period_len) < (longint'(high_len) << 32))
            s.level = LEVEL_HIGH;
          else
            s.level = LEVEL_LOW;
        end
        s.last = (i == int'(whole) - 1);
        expected_samples.push_back(s);
      end
    endfunction

    function void note_beat(timer_beat_t b);
      if (b.cmd == CMD_RETUNE) retune(b.run, b.reload, b.compare);
      else advance(b.cycles);
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] got_level, logic got_last);
      pcm_beat_t want;
      if (expected_samples.size() == 0) begin
        $error("output beat with nothing pending: sample=%0d last=%0b", got_level, got_last);
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      if (got_level !== want.level) begin
        $error("sample: expected %0d, got %0d", want.level, got_level);
        mismatches++;
      end
      if (got_last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got_last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic                       cfg_idx_i = 1'b0;
  logic [CLK_W-1:0]           cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       cmd_i = 1'b0;
  logic                       timer_run_i = 1'b0;
  logic [7:0]                 reload_value_i = '0;
  logic [7:0]                 compare_value_i = '0;
  logic [8:0]                 cycles_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                       last_o;

  tone_scoreboard sb = new();
  bit calm = 0;
  bit hold_request = 0;

  logic [CLK_W-1:0] phase_clock [NUM_PHASES] =
    '{23'd0, 23'd400000, 23'd8000000, 23'd8388607, 23'd1000, 23'd1, 23'd0, 23'd0, 23'd600000};
  logic [CLK_W-1:0] phase_ceiling [NUM_PHASES] =
    '{23'd0, 23'd100000, 23'd1, 23'h7FFFFF, 23'd20000, 23'd131071, 23'd0, 23'd0, 23'd20000};
  int unsigned phase_beats [NUM_PHASES] = '{45, 55, 25, 45, 30, 15, 60, 50, 35};

  timer_pwm_square_wave_synth u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .timer_run_i    (timer_run_i),
    .reload_value_i (reload_value_i),
    .compare_value_i(compare_value_i),
    .cycles_i       (cycles_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_o       (sample_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_sample(sample_o, last_o);
  end

  // Output back-pressure: alternating free and stalled stretches, plus one long hold-off.
  initial begin
    int unsigned stretch;
    bit stalling;
    stretch = 0;
    stalling = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 0;
        out_stall_i <= 1'b1;
        repeat (500) @(negedge clk_i);
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stalling = !stalling;
          if (stalling)
            stretch = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(10, 60);
          else
            stretch = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(30, 80);
        end
        stretch--;
        out_stall_i <= stalling;
      end
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic timer_beat_t make_beat(logic cmd, logic run, logic [7:0] reload,
                                            logic [7:0] compare, logic [8:0] cycles);
    timer_beat_t b;
    b.cmd = cmd;
    b.run = run;
    b.reload = reload;
    b.compare = compare;
    b.cycles = cycles;
    return b;
  endfunction

  // Mostly ticks; retunes mostly running with compare above reload, some arbitrary register values.
  function automatic timer_beat_t random_beat();
    timer_beat_t b;
    b.cmd = ($urandom_range(0, 99) < 72) ? CMD_TICK : CMD_RETUNE;
    b.run = 1'($urandom_range(0, 1));
    b.reload = 8'($urandom_range(0, 255));
    b.compare = 8'($urandom_range(0, 255));
    b.cycles = 9'($urandom_range(0, 511));
    if (b.cmd == CMD_TICK && $urandom_range(0, 99) < 10) begin
      b.cycles = $urandom_range(0, 1) ? 9'd511 : 9'd0;
    end else if (b.cmd == CMD_RETUNE && $urandom_range(0, 99) < 75) begin
      b.run = 1'b1;
      b.reload = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 200))
                                              : 8'($urandom_range(0, 254));
      b.compare = 8'($urandom_range(32'(b.reload) + 32'd1, 255));
    end
    return b;
  endfunction

  task automatic send_beat(timer_beat_t b);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    cmd_i           <= b.cmd;
    timer_run_i     <= b.run;
    reload_value_i  <= b.reload;
    compare_value_i <= b.compare;
    cycles_i        <= b.cycles;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(b);
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic write_reg(logic idx, logic [CLK_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // A retune leaves nothing to wait for, so allow its divider time to finish as well.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_beat(make_beat(CMD_TICK, 1'b1, 8'hFF, 8'hFF, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd511));
    send_beat(make_beat(CMD_RETUNE, 1'b0, 8'd0, 8'd128, 9'd511));
    send_beat(make_beat(CMD_TICK, 1'b1, 8'h55, 8'hAA, 9'd300));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd255, 8'd255, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'hAA, 8'h55, 9'd200));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd0, 8'd0, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd200));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd100, 8'd50, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b1, 8'h00, 8'h00, 9'd150));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd254, 8'd255, 9'd0));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd250, 8'd253, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd511));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd0, 8'd255, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd511));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd0, 8'd1, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd511));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd128, 8'd192, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd511));
    // Period of 30 puts the tone exactly on the default audible ceiling.
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd226, 8'd240, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd511));
    send_beat(make_beat(CMD_RETUNE, 1'b1, 8'd225, 8'd240, 9'd0));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd1));
    send_beat(make_beat(CMD_TICK, 1'b0, 8'h00, 8'h00, 9'd511));
  endtask

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CLK_W-1:0] clock_value;
    logic [CLK_W-1:0] ceiling_value;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      clock_value = phase_clock[p];
      ceiling_value = phase_ceiling[p];
      if (p == 6 || p == 7) begin
        clock_value = CLK_W'($urandom_range(400000, 8000000));
        ceiling_value = CLK_W'($urandom_range(1, 100000));
      end
      write_reg(REG_CLOCK_FREQ, clock_value);
      write_reg(REG_AUDIBLE_CEIL, ceiling_value);
      calm = (p == 1 || p == 5);
      for (int i = 0; i < int'(phase_beats[p]); i++) begin
        send_beat(random_beat());
        if (p == 3 && i == 15) hold_request = 1;
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tpsw_pkg.sv
hw/rtl/tpsw_div.sv
hw/rtl/timer_pwm_square_wave_synth.sv
dv/timer_pwm_square_wave_synth_test.sv
